>>> src/spr_pkg.sv
package spr_pkg;

	localparam int PAN_TABLE_DEPTH = 256;
	localparam int SAMPLE_WIDTH = 16;
	localparam int FILTER_WIDTH = 24;
	localparam int GUARD_BITS = FILTER_WIDTH - SAMPLE_WIDTH;
	localparam int CFG_WIDTH = 16;
	localparam int IDX_W = $clog2(PAN_TABLE_DEPTH + 1);

	localparam logic [15:0] UNITY = 16'd32768;
	localparam logic [14:0] RAMP_FULL = 15'd8481;
	localparam logic [15:0] K_ATT = 16'd14746;
	localparam logic [15:0] K_LP = 16'd27853;
	localparam logic [15:0] K_PITCH = 16'd6554;
	localparam logic [15:0] RATE_MIN = 16'd205;
	localparam logic [15:0] RATE_MAX = 16'd32768;

	localparam int NUM_W = $clog2(RAMP_FULL);
	localparam int QUO_W = 15;
	localparam int RECIP_M_W = 28;
	localparam logic [RECIP_M_W-1:0] RECIP_M = 28'd259288204;
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_P_W = NUM_W + RECIP_M_W;

	localparam int MUL_A_W = FILTER_WIDTH + 2;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int R15_W = MUL_P_W - 15;
	localparam int ROUT_W = MUL_P_W - 15 - GUARD_BITS;

	localparam longint unsigned SIN_A = 64'd1686629713;
	localparam longint unsigned SIN_B = 64'd693598563;
	localparam longint unsigned SIN_C = 64'd80710674;

	typedef enum logic [1:0] {
		REG_PAN = 2'd0,
		REG_FACING = 2'd1,
		REG_VOLUME = 2'd2,
		REG_PITCH = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_ATT,
		S_LP,
		S_PITCH,
		S_GL,
		S_GR,
		S_GLA,
		S_GRA,
		S_RATE,
		S_FILT,
		S_FUPD,
		S_OL,
		S_OR,
		S_WB
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [15:0] sine_tbl_t [0:PAN_TABLE_DEPTH];

	// Quarter-wave sine, polynomial evaluated in Q2.30 and rounded to Q1.15.
	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned p;
		for (int k = 0; k <= PAN_TABLE_DEPTH; k++) begin
			x = (longint'(k) << 30) / PAN_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			p = SIN_A - ((x2 * (SIN_B - ((x2 * SIN_C) >> 30))) >> 30);
			p = (x * p) >> 30;
			t[k] = 16'((p + 64'd16384) >> 15);
		end
		return t;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

>>> src/spr_div.sv
module spr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [15:0]         facing,
	output logic [15:0]                behind,
	output spr_pkg::div_stat_t         stat
);
	import spr_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic                  full_q;
	logic [NUM_W-1:0]      num_q;
	logic [QUO_W-1:0]      quo_q;
	logic [16:0]           neg_facing;
	logic [RECIP_P_W-1:0]  recip_prod;

	assign neg_facing = 17'd0 - {facing[15], facing};
	assign recip_prod = RECIP_P_W'(num_q) * RECIP_P_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q <= facing[15];
				full_q <= neg_facing >= 17'(RAMP_FULL);
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The negated facing, scaled by 2^15, over sin 15 degrees by reciprocal multiplication.
	// The reciprocal carries enough bits that the quotient is exact below the ramp end.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (neg_facing < 17'(RAMP_FULL)) ? neg_facing[NUM_W-1:0] : '0;
		end else if (busy_q) begin
			quo_q <= recip_prod[RECIP_SHIFT +: QUO_W];
		end
	end

	assign behind = !neg_q ? 16'd0 : (full_q ? UNITY : {1'b0, quo_q});
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> src/spr_mul.sv
module spr_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [spr_pkg::MUL_A_W-1:0]  a,
	input  logic signed [spr_pkg::MUL_B_W-1:0]  b,
	output logic signed [spr_pkg::R15_W-1:0]    r15,
	output logic signed [spr_pkg::ROUT_W-1:0]   rout
);
	import spr_pkg::*;

	localparam logic signed [MUL_P_W-1:0] HALF15 = MUL_P_W'(1) << 14;
	localparam logic signed [MUL_P_W-1:0] HALFOUT = MUL_P_W'(1) << (14 + GUARD_BITS);

	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [MUL_P_W-1:0] sum15;
	logic signed [MUL_P_W-1:0] sumout;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	// Round to nearest with halves going up, then drop the fraction.
	assign sum15 = prod_q + HALF15;
	assign sumout = prod_q + HALFOUT;
	assign r15 = sum15[MUL_P_W-1:15];
	assign rout = sumout[MUL_P_W-1:15+GUARD_BITS];

endmodule

>>> src/spatial_ping_renderer_top.sv
// Channel   Signals                                         Direction
// input     in_valid, in_ready, sample, first_of_clip       into block
// output    out_valid, out_ready, left_sample,              out of block
//           right_sample, playback_rate
// config    wr_en, wr_index, wr_data                        into block
//
// An item with nonzero volume first has its behind amount computed by the divider,
// then runs through the steps of the shared multiplier sequence, S_ATT to S_WB.
// in_ready is high only in idle, so a new item waits until the last result is loaded.
// An item at zero volume is taken without starting the sequencer and gives no result.
// Reset sets the registers to their defaults and clears the filter state.
// A finished result waits in the output register; the sequencer stalls only when
// the next result is ready while that register is still full.
module spatial_ping_renderer_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [spr_pkg::SAMPLE_WIDTH-1:0]   sample,
	input  logic                                      first_of_clip,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [spr_pkg::SAMPLE_WIDTH-1:0]   left_sample,
	output logic signed [spr_pkg::SAMPLE_WIDTH-1:0]   right_sample,
	output logic [15:0]                               playback_rate,
	input  logic                                      wr_en,
	input  logic [1:0]                                wr_index,
	input  logic [spr_pkg::CFG_WIDTH-1:0]             wr_data
);
	import spr_pkg::*;

	localparam int PAN_W = 16 + IDX_W;
	localparam logic signed [ROUT_W-1:0] SAT_HI = ROUT_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ROUT_W-1:0] SAT_LO = -SAT_HI - ROUT_W'(1);

	state_t                          state_q;
	state_t                          state_nx;

	logic [15:0]                     pan_q;
	logic [15:0]                     facing_q;
	logic [15:0]                     volume_q;
	logic [15:0]                     pitch_q;

	logic signed [SAMPLE_WIDTH-1:0]  sample_q;
	logic                            first_q;
	logic [15:0]                     att_q;
	logic [15:0]                     coef_q;
	logic [15:0]                     fac_q;
	logic [15:0]                     gl_q;
	logic [15:0]                     gr_q;
	logic [15:0]                     rate_q;
	logic signed [FILTER_WIDTH-1:0]  filt_q;
	logic signed [SAMPLE_WIDTH-1:0]  left_q;

	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  out_left_q;
	logic signed [SAMPLE_WIDTH-1:0]  out_right_q;
	logic [15:0]                     out_rate_q;

	logic [15:0]                     vol;
	logic [15:0]                     pan_u;
	logic [PAN_W-1:0]                pan_scaled;
	logic [IDX_W-1:0]                idx;
	logic [IDX_W-1:0]                tbl_addr;
	logic [15:0]                     tbl_val;
	logic signed [FILTER_WIDTH-1:0]  y_start;
	logic signed [MUL_A_W-1:0]       diff;
	logic                            in_xfer;
	logic                            out_free;

	logic                            div_start;
	logic [15:0]                     behind;
	div_stat_t                       div_stat;

	logic                            mul_en;
	logic                            sel_cos;
	logic signed [MUL_A_W-1:0]       mul_a;
	logic signed [MUL_B_W-1:0]       mul_b;
	logic signed [R15_W-1:0]         r15;
	logic signed [ROUT_W-1:0]        rout;
	logic [15:0]                     r15_lo;
	logic [15:0]                     rate_clamped;
	logic signed [SAMPLE_WIDTH-1:0]  rout_sat;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [ROUT_W-1:0] v
	);
		logic signed [SAMPLE_WIDTH-1:0] res;
		if (v > SAT_HI) begin
			res = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (v < SAT_LO) begin
			res = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			res = v[SAMPLE_WIDTH-1:0];
		end
		return res;
	endfunction

	spr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.facing (facing_q),
		.behind (behind),
		.stat   (div_stat)
	);

	spr_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.r15  (r15),
		.rout (rout)
	);

	assign vol = (volume_q > UNITY) ? UNITY : volume_q;
	assign pan_u = pan_q ^ 16'h8000;
	assign pan_scaled = PAN_W'(pan_u) * PAN_W'(PAN_TABLE_DEPTH) + PAN_W'(32768);
	assign idx = pan_scaled[PAN_W-1:16];
	assign tbl_addr = sel_cos ? IDX_W'(PAN_TABLE_DEPTH) - idx : idx;
	assign tbl_val = SINE_TBL[tbl_addr];

	assign y_start = first_q ? '0 : filt_q;
	assign diff = {{(MUL_A_W - FILTER_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q,
		{GUARD_BITS{1'b0}}} - {{(MUL_A_W - FILTER_WIDTH){y_start[FILTER_WIDTH-1]}}, y_start};

	assign r15_lo = r15[15:0];
	assign rate_clamped = (r15 < R15_W'(RATE_MIN)) ? RATE_MIN :
		((r15 > R15_W'(RATE_MAX)) ? RATE_MAX : r15_lo);
	assign rout_sat = sat_sample(rout);

	assign in_xfer = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && vol != 16'd0) begin
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_nx = S_ATT;
				end
			end
			S_ATT:   state_nx = S_LP;
			S_LP:    state_nx = S_PITCH;
			S_PITCH: state_nx = S_GL;
			S_GL:    state_nx = S_GR;
			S_GR:    state_nx = S_GLA;
			S_GLA:   state_nx = S_GRA;
			S_GRA:   state_nx = S_RATE;
			S_RATE:  state_nx = S_FILT;
			S_FILT:  state_nx = S_FUPD;
			S_FUPD:  state_nx = S_OL;
			S_OL:    state_nx = S_OR;
			S_OR:    state_nx = S_WB;
			S_WB: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_start = 1'b0;
		mul_en = 1'b1;
		sel_cos = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				div_start = in_xfer && vol != 16'd0;
				mul_en = 1'b0;
			end
			S_DIV: begin
				mul_en = 1'b0;
			end
			S_ATT: begin
				mul_a = MUL_A_W'(behind);
				mul_b = MUL_B_W'(K_ATT);
			end
			S_LP: begin
				mul_a = MUL_A_W'(behind);
				mul_b = MUL_B_W'(K_LP);
			end
			S_PITCH: begin
				mul_a = MUL_A_W'(behind);
				mul_b = MUL_B_W'(K_PITCH);
			end
			S_GL: begin
				sel_cos = 1'b1;
				mul_a = MUL_A_W'(tbl_val);
				mul_b = MUL_B_W'(vol);
			end
			S_GR: begin
				mul_a = MUL_A_W'(tbl_val);
				mul_b = MUL_B_W'(vol);
			end
			S_GLA: begin
				mul_a = MUL_A_W'(gl_q);
				mul_b = MUL_B_W'(att_q);
			end
			S_GRA: begin
				mul_a = MUL_A_W'(gr_q);
				mul_b = MUL_B_W'(att_q);
			end
			S_RATE: begin
				mul_a = MUL_A_W'(pitch_q);
				mul_b = MUL_B_W'(fac_q);
			end
			S_FILT: begin
				mul_a = diff;
				mul_b = MUL_B_W'(coef_q);
			end
			S_FUPD: begin
				mul_en = 1'b0;
			end
			S_OL: begin
				mul_a = {{(MUL_A_W - FILTER_WIDTH){filt_q[FILTER_WIDTH-1]}}, filt_q};
				mul_b = MUL_B_W'(gl_q);
			end
			S_OR: begin
				mul_a = {{(MUL_A_W - FILTER_WIDTH){filt_q[FILTER_WIDTH-1]}}, filt_q};
				mul_b = MUL_B_W'(gr_q);
			end
			S_WB: begin
				mul_en = 1'b0;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pan_q <= 16'd0;
			facing_q <= 16'd32767;
			volume_q <= UNITY;
			pitch_q <= 16'd4096;
			filt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (wr_en) begin
				case (reg_index_t'(wr_index))
					REG_PAN:    pan_q <= wr_data;
					REG_FACING: facing_q <= wr_data;
					REG_VOLUME: volume_q <= wr_data;
					REG_PITCH:  pitch_q <= wr_data;
					default: ;
				endcase
			end
			if (state_q == S_FILT) begin
				filt_q <= y_start;
			end else if (state_q == S_FUPD) begin
				filt_q <= filt_q + r15[FILTER_WIDTH-1:0];
			end
			if (state_q == S_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample;
			first_q <= first_of_clip;
		end
		case (state_q)
			S_LP:    att_q <= UNITY - r15_lo;
			S_PITCH: coef_q <= UNITY - r15_lo;
			S_GL:    fac_q <= UNITY - r15_lo;
			S_GR:    gl_q <= r15_lo;
			S_GLA:   gr_q <= r15_lo;
			S_GRA:   gl_q <= r15_lo;
			S_RATE:  gr_q <= r15_lo;
			S_FILT:  rate_q <= rate_clamped;
			S_OR:    left_q <= rout_sat;
			S_WB: begin
				if (out_free) begin
					out_left_q <= left_q;
					out_right_q <= rout_sat;
					out_rate_q <= rate_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_sample = out_left_q;
	assign right_sample = out_right_q;
	assign playback_rate = out_rate_q;

	a_idle_not_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy)
		else $error("Divider busy while the sequencer is idle.");

	a_att_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ATT |-> $past(div_stat.done))
		else $error("Gain sequence started before the behind amount was ready.");

	a_behind_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> behind <= UNITY)
		else $error("Behind amount above unity.");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (playback_rate >= RATE_MIN && playback_rate <= RATE_MAX))
		else $error("Playback rate outside its clamp range.");

	a_mute_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && vol == 16'd0) |=> state_q == S_IDLE)
		else $error("Transfer at zero volume started the sequencer.");

endmodule

>>> tb/spatial_ping_renderer_top_tb.sv
`timescale 1ns / 100ps

module spatial_ping_renderer_top_tb;
	import spr_pkg::*;

	localparam int LUT_DEPTH = 256;
	localparam int FILT_GUARD = 8;
	localparam longint unsigned POLY_A = 64'd1686629713;
	localparam longint unsigned POLY_B = 64'd693598563;
	localparam longint unsigned POLY_C = 64'd80710674;
	localparam longint unsigned SIN15_Q15 = 64'd8481;
	localparam longint unsigned FULL_SCALE = 64'd32768;
	localparam longint unsigned ATT_K = 64'd14746;
	localparam longint unsigned LPF_K = 64'd27853;
	localparam longint unsigned PITCH_K = 64'd6554;
	localparam longint unsigned MIN_RATE = 64'd205;
	localparam longint unsigned MAX_RATE = 64'd32768;
	localparam int SETTLE_CYCLES = 40;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int RANDOM_RESULTS = 450;

	typedef struct {
		logic signed [15:0] left_val;
		logic signed [15:0] right_val;
		logic [15:0] rate_val;
	} stereo_pair_t;

	class stereo_checker;
		logic [15:0] pan_reg;
		logic [15:0] facing_reg;
		logic [15:0] volume_reg;
		logic [15:0] pitch_reg;
		longint filter_acc;
		longint unsigned sine_lut [0:LUT_DEPTH];
		stereo_pair_t expected_pairs [$];
		int unsigned mismatches;
		int unsigned voiced;
		int unsigned muted;
		int unsigned checked;

		function new();
			longint unsigned x;
			longint unsigned xsq;
			longint unsigned poly;
			for (int k = 0; k <= LUT_DEPTH; k++) begin
				x = (longint'(k) << 30) / LUT_DEPTH;
				xsq = (x * x) >> 30;
				poly = POLY_A - ((xsq * (POLY_B - ((xsq * POLY_C) >> 30))) >> 30);
				sine_lut[k] = (((x * poly) >> 30) + 64'd16384) >> 15;
			end
			pan_reg = 16'd0;
			facing_reg = 16'd32767;
			volume_reg = 16'd32768;
			pitch_reg = 16'd4096;
			filter_acc = 0;
			mismatches = 0;
			voiced = 0;
			muted = 0;
			checked = 0;
		endfunction

		function longint unsigned rq15(longint unsigned a);
			return (a + 64'd16384) >> 15;
		endfunction

		function longint shr_round(longint v, int n);
			return (v + (64'sd1 << (n - 1))) >>> n;
		endfunction

		function logic signed [15:0] clip16(longint v);
			if (v > 32767)
				return 16'sd32767;
			if (v < -32768)
				return -16'sd32768;
			return v[15:0];
		endfunction

		function void apply_reg(reg_index_t idx, logic [15:0] val);
			case (idx)
				REG_PAN: pan_reg = val;
				REG_FACING: facing_reg = val;
				REG_VOLUME: volume_reg = val;
				REG_PITCH: pitch_reg = val;
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [15:0] s, logic first);
			longint unsigned vol;
			longint unsigned mag;
			longint unsigned behind;
			longint unsigned att;
			longint unsigned coef;
			longint unsigned fac;
			longint unsigned gl;
			longint unsigned gr;
			longint unsigned rate;
			longint idx;
			longint dev;
			stereo_pair_t p;
			vol = (volume_reg > 16'd32768) ? FULL_SCALE : volume_reg;
			if (vol == 0) begin
				muted++;
				return;
			end
			behind = 0;
			if (facing_reg[15]) begin
				mag = 64'd65536 - facing_reg;
				behind = (mag << 15) / SIN15_Q15;
				if (behind > FULL_SCALE)
					behind = FULL_SCALE;
			end
			att = FULL_SCALE - rq15(behind * ATT_K);
			coef = FULL_SCALE - rq15(behind * LPF_K);
			fac = FULL_SCALE - rq15(behind * PITCH_K);
			idx = ((longint'($signed(pan_reg)) + 32768) * LUT_DEPTH + 32768) >>> 16;
			gl = rq15(sine_lut[LUT_DEPTH - idx] * vol);
			gr = rq15(sine_lut[idx] * vol);
			gl = rq15(gl * att);
			gr = rq15(gr * att);
			if (first)
				filter_acc = 0;
			dev = (longint'(s) <<< FILT_GUARD) - filter_acc;
			filter_acc += shr_round(longint'(coef) * dev, 15);
			rate = rq15(pitch_reg * fac);
			if (rate < MIN_RATE)
				rate = MIN_RATE;
			if (rate > MAX_RATE)
				rate = MAX_RATE;
			p.left_val = clip16(shr_round(filter_acc * longint'(gl), 15 + FILT_GUARD));
			p.right_val = clip16(shr_round(filter_acc * longint'(gr), 15 + FILT_GUARD));
			p.rate_val = rate[15:0];
			expected_pairs.push_back(p);
			voiced++;
		endfunction

		function void match_pair(logic signed [15:0] l, logic signed [15:0] r, logic [15:0] rt);
			stereo_pair_t e;
			if (expected_pairs.size() == 0) begin
				$error("unexpected result: left %0d right %0d rate %0d", l, r, rt);
				mismatches++;
				return;
			end
			e = expected_pairs.pop_front();
			checked++;
			if (l !== e.left_val) begin
				$error("left_sample: expected %0d, actual %0d", e.left_val, l);
				mismatches++;
			end
			if (r !== e.right_val) begin
				$error("right_sample: expected %0d, actual %0d", e.right_val, r);
				mismatches++;
			end
			if (rt !== e.rate_val) begin
				$error("playback_rate: expected %0d, actual %0d", e.rate_val, rt);
				mismatches++;
			end
		endfunction

		function int awaiting();
			return expected_pairs.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample = '0;
	logic first_of_clip = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] left_sample;
	logic signed [SAMPLE_WIDTH-1:0] right_sample;
	logic [15:0] playback_rate;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = 2'd0;
	logic [CFG_WIDTH-1:0] wr_data = '0;

	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int unsigned settings_used = 1;
	int unsigned samples_sent = 0;
	stereo_checker sb = new();

	spatial_ping_renderer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.first_of_clip(first_of_clip),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.playback_rate(playback_rate),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic signed [15:0] s, input logic first);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		first_of_clip <= first;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.take_sample(s, first);
		samples_sent++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.awaiting() > 0);
	endtask

	task automatic load_settings(input logic [15:0] pan, input logic [15:0] face,
			input logic [15:0] vol, input logic [15:0] pitch);
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_PAN;
		wr_data <= pan;
		@(posedge clk);
		wr_index <= REG_FACING;
		wr_data <= face;
		@(posedge clk);
		wr_index <= REG_VOLUME;
		wr_data <= vol;
		@(posedge clk);
		wr_index <= REG_PITCH;
		wr_data <= pitch;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.apply_reg(REG_PAN, pan);
		sb.apply_reg(REG_FACING, face);
		sb.apply_reg(REG_VOLUME, vol);
		sb.apply_reg(REG_PITCH, pitch);
		settings_used++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 1))
					do @(posedge clk); while (out_valid !== 1'b1);
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.match_pair(left_sample, right_sample, playback_rate);
		end
	end

	initial begin
		#2_000_000;
		$display("spatial_ping_renderer_top_tb: errors");
		$finish;
	end

	initial begin
		int unsigned target;
		int unsigned phase;
		int n;
		logic [15:0] pan;
		logic [15:0] face;
		logic [15:0] vol;
		logic [15:0] pitch;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(16'h7fff, 1'b1);
		send_item(16'h8000, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'hffff, 1'b0);

		// Full left, fully behind, volume above unity, rate clamped high.
		load_settings(16'h8000, 16'h8000, 16'hffff, 16'hffff);
		send_item(16'h7fff, 1'b1);
		send_item(16'h8000, 1'b0);
		send_item(16'h7fff, 1'b0);

		// Full right, barely behind, minimum volume, rate clamped low.
		load_settings(16'h7fff, 16'hffff, 16'h0001, 16'h0000);
		send_item(16'h8000, 1'b1);
		send_item(16'h7fff, 1'b0);

		// A clip start at zero volume must leave the filter running.
		load_settings(16'h0000, 16'hf060, 16'h0000, 16'd4096);
		send_item(16'sd12345, 1'b1);
		send_item(16'h8000, 1'b1);
		load_settings(16'h0000, 16'hf060, 16'd32768, 16'd4096);
		send_item(16'sd20000, 1'b0);
		send_item(-16'sd20000, 1'b1);

		load_settings(16'hffff, 16'hdedf, 16'd32768, 16'd4096);
		send_item(16'h7fff, 1'b1);
		send_item(16'h8000, 1'b0);
		send_item(16'h7fff, 1'b0);
		send_item(16'h8000, 1'b0);

		target = sb.voiced + RANDOM_RESULTS;
		phase = 0;
		while (sb.voiced < target) begin
			case ($urandom_range(0, 5))
				0: pan = 16'h8000;
				1: pan = 16'h7fff;
				2: pan = 16'h0000;
				default: pan = 16'($urandom);
			endcase
			case ($urandom_range(0, 6))
				0: face = 16'h7fff;
				1: face = 16'h8000;
				2, 3: face = 16'd0 - 16'($urandom_range(0, 8600));
				4: face = 16'h0000;
				default: face = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: vol = 16'd0;
				1: vol = 16'd32768;
				2: vol = 16'hffff;
				3: vol = 16'($urandom_range(32769, 65535));
				4: vol = 16'd1;
				default: vol = 16'($urandom_range(1, 32768));
			endcase
			case ($urandom_range(0, 5))
				0: pitch = 16'd0;
				1: pitch = 16'hffff;
				2: pitch = 16'd4096;
				3: pitch = 16'($urandom_range(0, 300));
				default: pitch = 16'($urandom);
			endcase
			if (phase == 2 && vol == 16'd0)
				vol = 16'd32768;
			load_settings(pan, face, vol, pitch);
			no_idle = (phase % 4 == 2);
			if (phase == 2)
				hold_req = 1'b1;
			n = (vol == 16'd0) ? 6 : $urandom_range(20, 45);
			for (int i = 0; i < n; i++) begin
				if (phase == 5 && i == n / 2)
					quiesce();
				send_item(pick_sample(), (i == 0) || ($urandom_range(0, 11) == 0));
			end
			phase++;
		end
		no_idle = 1'b0;

		in_valid <= 1'b0;
		for (int i = 0; i < 5000 && sb.awaiting() > 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.awaiting() > 0) begin
			$error("%0d expected results never arrived", sb.awaiting());
			sb.mismatches++;
		end

		$display("Ran %0d register settings with %0d samples sent, %0d of them muted.",
			settings_used, samples_sent, sb.muted);
		$display("Checked %0d stereo results field by field.", sb.checked);
		if (sb.mismatches == 0) begin
			$display("spatial_ping_renderer_top_tb: clean");
		end else begin
			$display("spatial_ping_renderer_top_tb: errors");
		end
		$finish;
	end

endmodule
